// ===== src/wces_pkg.sv =====
// Shared constants, field layout and controller/datapath interface types.
package wces_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_CHANNELS_DEF = 64;
    localparam int ENERGY_BITS_DEF  = 24;

    // Field widths.
    localparam int CH_W   = 6;
    localparam int EN_W   = 24;
    localparam int TIME_W = 32;

    // Input tdata layout: channel, energy, hit_time from the lowest bit up.
    localparam int CH_LSB      = 0;
    localparam int EN_LSB      = CH_LSB + CH_W;
    localparam int TIME_LSB    = EN_LSB + EN_W;
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 1;

    // Output tdata layout: out_channel, out_energy from the lowest bit up.
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 1;

    // Request kinds carried in s_tuser.
    localparam logic REQ_HIT   = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_CUT   = 2'd2;

    localparam logic [TIME_W-1:0] WINDOW_START_RST = 32'd0;
    localparam logic [TIME_W-1:0] WINDOW_END_RST   = 32'd100;
    localparam logic [EN_W-1:0]   ENERGY_CUT_RST   = 24'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic hit_load;       // a hit transaction is taken this cycle
        logic scan_start;     // point the table scan at channel zero
        logic scan_on;        // table scan owns the read port
        logic scan_adv;       // step the scan to the next channel
        logic pend_load;      // current channel goes to the holding slot
        logic out_load_pend;  // holding slot goes out as a non-final result
        logic out_final;      // final result of the flush goes out
        logic hit_clr;        // clear every hit flag
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic qual;           // scanned channel was hit and is above the cut
        logic pend_valid;     // holding slot is occupied
        logic out_free;       // output register can take a result this cycle
        logic idx_last;       // scan sits on the highest channel
    } sts_t;

endpackage

// ===== src/wces_dp.sv =====
// Datapath: configuration registers, sum memory, hit flags, scan and output register.
module wces_dp #(
    parameter int NUM_CHANNELS = wces_pkg::NUM_CHANNELS_DEF,
    parameter int ENERGY_BITS  = wces_pkg::ENERGY_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wces_pkg::cmd_t                      cmd,
    output wces_pkg::sts_t                      sts,
    input  logic [wces_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wces_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    output logic [wces_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [wces_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wces_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int AW = ((ENERGY_BITS > wces_pkg::EN_W) ? ENERGY_BITS : wces_pkg::EN_W) + 1;
    localparam logic [wces_pkg::CH_W:0] CH_LIMIT = (wces_pkg::CH_W + 1)'(NUM_CHANNELS);
    localparam logic [AW-1:0] SUM_MAX = {{(AW - ENERGY_BITS){1'b0}}, {ENERGY_BITS{1'b1}}};
    localparam logic [CW-1:0] IDX_LAST = CW'(NUM_CHANNELS - 1);

    // Configuration registers.
    logic [wces_pkg::TIME_W-1:0] ws_reg, we_reg;
    logic [wces_pkg::EN_W-1:0]   cut_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg  <= wces_pkg::WINDOW_START_RST;
            we_reg  <= wces_pkg::WINDOW_END_RST;
            cut_reg <= wces_pkg::ENERGY_CUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                wces_pkg::REG_WINDOW_START: ws_reg  <= cfg_wdata[wces_pkg::TIME_W-1:0];
                wces_pkg::REG_WINDOW_END:   we_reg  <= cfg_wdata[wces_pkg::TIME_W-1:0];
                wces_pkg::REG_ENERGY_CUT:   cut_reg <= cfg_wdata[wces_pkg::EN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input fields.
    logic [wces_pkg::CH_W-1:0]   in_ch;
    logic [wces_pkg::EN_W-1:0]   in_en;
    logic [wces_pkg::TIME_W-1:0] in_t;
    logic                        in_ok;

    assign in_ch = s_tdata[wces_pkg::CH_LSB +: wces_pkg::CH_W];
    assign in_en = s_tdata[wces_pkg::EN_LSB +: wces_pkg::EN_W];
    assign in_t  = s_tdata[wces_pkg::TIME_LSB +: wces_pkg::TIME_W];
    assign in_ok = ({1'b0, in_ch} < CH_LIMIT) && (in_t >= ws_reg) && (in_t < we_reg);

    // Storage.
    logic [ENERGY_BITS-1:0]  mem [NUM_CHANNELS];
    logic [ENERGY_BITS-1:0]  mem_rd_reg;
    logic [NUM_CHANNELS-1:0] hit_reg;
    logic                    hit_rd_reg;
    logic [CW-1:0]           rd_addr;

    // Scan state.
    logic [CW-1:0] idx_reg, idx_inc;
    assign idx_inc = idx_reg + CW'(1);

    always_comb begin
        priority if (cmd.scan_start) begin
            rd_addr = '0;
        end else if (cmd.scan_on) begin
            rd_addr = cmd.scan_adv ? idx_inc : idx_reg;
        end else begin
            rd_addr = in_ch[CW-1:0];
        end
    end

    // Accumulate stage.
    logic                   p1_v_reg;
    logic [CW-1:0]          p1_ch_reg;
    logic [wces_pkg::EN_W-1:0] p1_en_reg;
    logic                   wr_v_reg;
    logic [CW-1:0]          wr_ch_reg;
    logic [ENERGY_BITS-1:0] wr_data_reg;
    logic [ENERGY_BITS-1:0] s1_base, s1_sum;
    logic [AW-1:0]          s1_ext;

    always_comb begin
        // A write at the previous edge is not yet in the registered read data.
        if (wr_v_reg && (wr_ch_reg == p1_ch_reg)) begin
            s1_base = wr_data_reg;
        end else if (hit_rd_reg) begin
            s1_base = mem_rd_reg;
        end else begin
            s1_base = '0;
        end
        s1_ext = {{(AW - ENERGY_BITS){1'b0}}, s1_base}
               + {{(AW - wces_pkg::EN_W){1'b0}}, p1_en_reg};
        s1_sum = (s1_ext > SUM_MAX) ? SUM_MAX[ENERGY_BITS-1:0] : s1_ext[ENERGY_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            wr_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= cmd.hit_load && in_ok;
            wr_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_ch_reg   <= in_ch[CW-1:0];
        p1_en_reg   <= in_en;
        wr_ch_reg   <= p1_ch_reg;
        wr_data_reg <= s1_sum;
    end

    always_ff @(posedge aclk) begin
        if (p1_v_reg) begin
            mem[p1_ch_reg] <= s1_sum;
        end
    end

    always_ff @(posedge aclk) begin
        mem_rd_reg <= mem[rd_addr];
        hit_rd_reg <= hit_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= '0;
        end else if (cmd.hit_clr) begin
            hit_reg <= '0;
        end else if (p1_v_reg) begin
            hit_reg[p1_ch_reg] <= 1'b1;
        end
    end

    // Scan evaluation.
    logic [AW-1:0] sc_ext;
    assign sc_ext = {{(AW - ENERGY_BITS){1'b0}}, mem_rd_reg};

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            idx_reg <= '0;
        end else if (cmd.scan_adv) begin
            idx_reg <= idx_inc;
        end
    end

    // Holding slot and output register.
    logic                      pend_v_reg;
    logic [wces_pkg::CH_W-1:0] pend_ch_reg;
    logic [wces_pkg::EN_W-1:0] pend_en_reg;
    logic                      m_v_reg, m_last_reg, m_empty_reg;
    logic [wces_pkg::CH_W-1:0] m_ch_reg;
    logic [wces_pkg::EN_W-1:0] m_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg <= 1'b0;
        end else if (cmd.pend_load) begin
            pend_v_reg <= 1'b1;
        end else if (cmd.out_final) begin
            pend_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pend_load) begin
            pend_ch_reg <= wces_pkg::CH_W'(idx_reg);
            pend_en_reg <= sc_ext[wces_pkg::EN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg <= 1'b0;
        end else if (cmd.out_load_pend || cmd.out_final) begin
            m_v_reg <= 1'b1;
        end else if (m_tready) begin
            m_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load_pend) begin
            m_ch_reg    <= pend_ch_reg;
            m_en_reg    <= pend_en_reg;
            m_last_reg  <= 1'b0;
            m_empty_reg <= 1'b0;
        end else if (cmd.out_final) begin
            m_last_reg  <= 1'b1;
            m_empty_reg <= !pend_v_reg;
            m_ch_reg    <= pend_v_reg ? pend_ch_reg : '0;
            m_en_reg    <= pend_v_reg ? pend_en_reg : '0;
        end
    end

    assign sts.qual       = hit_rd_reg
                          && (sc_ext > {{(AW - wces_pkg::EN_W){1'b0}}, cut_reg});
    assign sts.pend_valid = pend_v_reg;
    assign sts.out_free   = !m_v_reg || m_tready;
    assign sts.idx_last   = (idx_reg == IDX_LAST);

    assign m_tvalid = m_v_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_empty_reg;
    assign m_tdata  = {{(wces_pkg::OUT_TDATA_W - wces_pkg::CH_W - wces_pkg::EN_W){1'b0}},
                       m_en_reg, m_ch_reg};

endmodule

// ===== src/wces_ctrl.sv =====
// Controller: input handshake and the flush scan sequence.
module wces_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [wces_pkg::IN_TUSER_W-1:0]    s_tuser,
    output wces_pkg::cmd_t                     cmd,
    input  wces_pkg::sts_t                     sts
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0] == wces_pkg::REQ_FLUSH) begin
                        state_next = ST_PRIME;
                    end else begin
                        cmd.hit_load = 1'b1;
                    end
                end
            end
            ST_PRIME: begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_on = 1'b1;
                if (!sts.qual) begin
                    cmd.scan_adv = 1'b1;
                end else if (!sts.pend_valid) begin
                    cmd.pend_load = 1'b1;
                    cmd.scan_adv  = 1'b1;
                end else if (sts.out_free) begin
                    cmd.out_load_pend = 1'b1;
                    cmd.pend_load     = 1'b1;
                    cmd.scan_adv      = 1'b1;
                end
                if (cmd.scan_adv && sts.idx_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_final = 1'b1;
                    cmd.hit_clr   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/windowed_channel_energy_sum_core.sv =====
// Top level of the windowed per-channel energy summer.
//
// Channel  | Direction | Payload
// s_ (in)  | slave     | tdata: channel[5:0], energy[29:6], hit_time[61:30]; tuser: req_type
// m_ (out) | master    | tdata: out_channel[5:0], out_energy[29:6]; tuser: empty_res; tlast
// cfg_     | write     | cfg_index selects window_start, window_end or energy_cut
//
// A hit transaction is taken every cycle while no flush is in progress; each hit
// on a valid channel inside the time window is summed in a read-add-write
// pipeline around the sum memory, with a bypass for a hit on the same channel
// in the next cycle. A flush primes the memory read, scans the channels from
// zero upward and then sends the final result; an output stall while a result
// waits delays it.
// Reset is synchronous and clears all hit flags at once; a sum entry whose flag
// is clear reads as zero, so the sum memory needs no clearing pass.
// With the output stalled and the holding slot full, the scan holds at a qualifying channel.
module windowed_channel_energy_sum_core #(
    parameter int NUM_CHANNELS = wces_pkg::NUM_CHANNELS_DEF,
    parameter int ENERGY_BITS  = wces_pkg::ENERGY_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [wces_pkg::IN_TDATA_W-1:0]     s_tdata,   // channel, energy, hit_time
    input  logic [wces_pkg::IN_TUSER_W-1:0]     s_tuser,   // req_type
    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wces_pkg::OUT_TDATA_W-1:0]    m_tdata,   // out_channel, out_energy
    output logic [wces_pkg::OUT_TUSER_W-1:0]    m_tuser,   // empty_res
    output logic                                m_tlast,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [wces_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wces_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    wces_pkg::cmd_t cmd;
    wces_pkg::sts_t sts;

    // The controller owns the input handshake and sequences the flush scan.
    wces_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds the table, the holding slot for the look-ahead on the
    // last flag, and the output register.
    wces_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ENERGY_BITS  (ENERGY_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// ===== src/wces_chk.sv =====
// Port-level checker for the energy summer core and its bind statement.
module wces_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [wces_pkg::IN_TDATA_W-1:0]     s_tdata,
    input logic [wces_pkg::IN_TUSER_W-1:0]     s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [wces_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic [wces_pkg::OUT_TUSER_W-1:0]    m_tuser,
    input logic                                m_tlast,
    input logic                                cfg_wr_en,
    input logic [wces_pkg::CFG_IDX_W-1:0]      cfg_index,
    input logic [wces_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // An empty result is the final one of its flush and carries zero fields.
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
        else $error("malformed empty result");

    // A flush transaction closes the input right after it is taken.
    a_flush_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == wces_pkg::REQ_FLUSH) |=> !s_tready)
        else $error("input open right after a flush");

    // A hit taken while no result is pending never produces a result in the following cycle.
    a_hit_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && s_tvalid && s_tready && (s_tuser[0] == wces_pkg::REQ_HIT) |=> !m_tvalid)
        else $error("result after a hit");

    // Reset leaves no result pending.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind windowed_channel_energy_sum_core wces_chk u_wces_chk (.*);
